[rtl/core/hrbo_pkg.sv]
// Shared types and constants for the histogram rebinning core.
// No dependencies; imported by every module in rtl/core except hrbo_ram.
`default_nettype none

package hrbo_pkg;

    localparam int MAX_SRC_BINS = 64;
    localparam int MAX_TGT_BINS = 64;

    localparam int SRC_AW    = $clog2(MAX_SRC_BINS);
    localparam int TGT_AW    = $clog2(MAX_TGT_BINS);
    localparam int CNT_W     = 7;
    localparam int EDGE_W    = 32;
    localparam int VAL_W     = 32;
    localparam int OUT_W     = 40;
    localparam int IDX_W     = 6;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W     = 32;
    localparam int IN_DATA_W = 32;
    localparam int OUT_DATA_W = 48;

    // scaled-edge arithmetic
    localparam int SPAN_W  = EDGE_W + 1;
    localparam int SCALE_W = 2 * CNT_W;
    localparam int POS_W   = 48;
    localparam int DIV_W   = 40;
    localparam int Q_W     = 17;
    localparam int DIV_STEPS = Q_W;
    localparam int DCNT_W  = $clog2(DIV_STEPS);
    localparam int PROD_W  = VAL_W + Q_W;
    localparam int ACC_W   = 58;
    localparam int FRAC_W  = 16;

    localparam logic [CNT_W-1:0]  RST_SRC_COUNT = 7'd64;
    localparam logic [EDGE_W-1:0] RST_SRC_LOW   = 32'd0;
    localparam logic [EDGE_W-1:0] RST_SRC_HIGH  = 32'd4194304;
    localparam logic [CNT_W-1:0]  RST_TGT_COUNT = 7'd64;
    localparam logic [EDGE_W-1:0] RST_TGT_LOW   = 32'd0;
    localparam logic [EDGE_W-1:0] RST_TGT_HIGH  = 32'd4194304;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SRC_COUNT = 3'd0,
        REG_SRC_LOW   = 3'd1,
        REG_SRC_HIGH  = 3'd2,
        REG_TGT_COUNT = 3'd3,
        REG_TGT_LOW   = 3'd4,
        REG_TGT_HIGH  = 3'd5
    } cfg_reg_t;

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_SETUP1,
        ST_SETUP2,
        ST_SETUP3,
        ST_ROW,
        ST_PAIR,
        ST_DIV,
        ST_MUL,
        ST_ACC,
        ST_ADV,
        ST_EMIT,
        ST_ERR
    } state_t;

    typedef struct packed {
        logic in_ready;
        logic setup_scale;
        logic setup_base;
        logic setup_th;
        logic row_init;
        logic div_start;
        logic div_step;
        logic mul;
        logic acc_add;
        logic advance;
        logic emit_norm;
        logic emit_err;
        logic tgt_next;
        logic set_done;
    } ctrl_cmd_t;

    typedef struct packed {
        logic last_beat;
        logic range_err;
        logic overlap;
        logic last_src;
        logic last_tgt;
        logic div_done;
        logic out_free;
    } dp_status_t;

endpackage

`default_nettype wire

[rtl/core/histogram_rebin_overlap_core.sv]
// Top level of the fractional-overlap histogram rebinning core.
// Depends on hrbo_pkg, hrbo_ctrl, hrbo_dp (and hrbo_ram below it).
//
// Usage:
//  - Input stream (s_*): one beat per source bin, bin_value in s_tdata[31:0]
//    as Q16.16; s_tlast marks the last bin of a data set. Beats are taken one
//    per cycle while loading; bins beyond the source bin count are dropped,
//    bins never sent count as zero.
//  - After the s_tlast beat, s_tready stays low while the target bins are
//    computed. Setup forms the scale and the scaled edges; each target bin
//    then walks every source bin, and an overlapping pair also runs the
//    bit-serial weight divider, the multiply and the accumulate.
//  - Output stream (m_*): one beat per target bin in index order, tlast on
//    the final one; a bad range (zero count or non-positive width) gives a
//    single beat with m_tuser = 1, m_tlast = 1 and zero data.
//  - A one-entry output register holds each result; a stalled m_tready halts
//    the sequencer at the next result, and loading of the next data set
//    begins while the final result still waits.
//  - cfg_we/cfg_index/cfg_data write a register in one cycle; write only
//    when idle. Reset restores the register defaults and empties the store.
`default_nettype none

module histogram_rebin_overlap_core (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_we,
    input  wire logic [hrbo_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [hrbo_pkg::CFG_W-1:0]      cfg_data,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    input  wire logic [hrbo_pkg::IN_DATA_W-1:0]  s_tdata,   // [31:0] bin_value
    input  wire logic                            s_tlast,   // last_bin
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    output logic      [hrbo_pkg::OUT_DATA_W-1:0] m_tdata,   // [5:0] target_index, [45:6] target_value
    output logic                                 m_tlast,   // last_result
    output logic                                 m_tuser    // range_error
);
    import hrbo_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t status;

    hrbo_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .cmd    (cmd)
    );

    hrbo_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser),
        .cmd       (cmd),
        .status    (status)
    );

    // input is taken only while loading
    assign s_tready = cmd.in_ready;

endmodule

`default_nettype wire

[rtl/core/hrbo_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module hrbo_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

[rtl/core/hrbo_ctrl.sv]
// Sequencer for load, setup, pairwise overlap loop and result emission.
// Depends on hrbo_pkg.
`default_nettype none

module hrbo_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire hrbo_pkg::dp_status_t status,
    output hrbo_pkg::ctrl_cmd_t     cmd
);
    import hrbo_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_LOAD:   if (status.last_beat) state_next = ST_SETUP1;
            ST_SETUP1: state_next = status.range_err ? ST_ERR : ST_SETUP2;
            ST_SETUP2: state_next = ST_SETUP3;
            ST_SETUP3: state_next = ST_ROW;
            ST_ROW:    state_next = ST_PAIR;
            ST_PAIR:   state_next = status.overlap ? ST_DIV : ST_ADV;
            ST_DIV:    if (status.div_done) state_next = ST_MUL;
            ST_MUL:    state_next = ST_ACC;
            ST_ACC:    state_next = status.last_src ? ST_EMIT : ST_PAIR;
            ST_ADV:    state_next = status.last_src ? ST_EMIT : ST_PAIR;
            ST_EMIT:
            begin
                if (status.out_free)
                begin
                    state_next = status.last_tgt ? ST_LOAD : ST_ROW;
                end
            end
            ST_ERR:    if (status.out_free) state_next = ST_LOAD;
            default:   state_next = ST_LOAD;
        endcase
    end

    always_comb
    begin
        cmd = '0;
        case (state_reg)
            ST_LOAD:   cmd.in_ready    = 1'b1;
            ST_SETUP1: cmd.setup_scale = 1'b1;
            ST_SETUP2: cmd.setup_base  = 1'b1;
            ST_SETUP3: cmd.setup_th    = 1'b1;
            ST_ROW:    cmd.row_init    = 1'b1;
            ST_PAIR:   cmd.div_start   = status.overlap;
            ST_DIV:    cmd.div_step    = 1'b1;
            ST_MUL:    cmd.mul         = 1'b1;
            ST_ACC:
            begin
                cmd.acc_add = 1'b1;
                cmd.advance = 1'b1;
            end
            ST_ADV:    cmd.advance     = 1'b1;
            ST_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.emit_norm = 1'b1;
                    cmd.set_done  = status.last_tgt;
                    cmd.tgt_next  = !status.last_tgt;
                end
            end
            ST_ERR:
            begin
                if (status.out_free)
                begin
                    cmd.emit_err = 1'b1;
                    cmd.set_done = 1'b1;
                end
            end
            default:   cmd = '0;
        endcase
    end

endmodule

`default_nettype wire

[rtl/core/hrbo_dp.sv]
// Datapath: config registers, source store, scaled edges, divider,
// multiply-accumulate and output register. Depends on hrbo_pkg, hrbo_ram.
`default_nettype none

module hrbo_dp (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_we,
    input  wire logic [hrbo_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [hrbo_pkg::CFG_W-1:0]        cfg_data,
    input  wire logic                              s_tvalid,
    input  wire logic [hrbo_pkg::IN_DATA_W-1:0]    s_tdata,
    input  wire logic                              s_tlast,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    output logic      [hrbo_pkg::OUT_DATA_W-1:0]   m_tdata,
    output logic                                   m_tlast,
    output logic                                   m_tuser,
    input  wire hrbo_pkg::ctrl_cmd_t               cmd,
    output hrbo_pkg::dp_status_t                   status
);
    import hrbo_pkg::*;

    localparam int RES_W = ACC_W - FRAC_W;

    // configuration
    logic        [CNT_W-1:0]  src_cnt_reg;
    logic signed [EDGE_W-1:0] src_low_reg;
    logic signed [EDGE_W-1:0] src_high_reg;
    logic        [CNT_W-1:0]  tgt_cnt_reg;
    logic signed [EDGE_W-1:0] tgt_low_reg;
    logic signed [EDGE_W-1:0] tgt_high_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_cnt_reg  <= RST_SRC_COUNT;
            src_low_reg  <= RST_SRC_LOW;
            src_high_reg <= RST_SRC_HIGH;
            tgt_cnt_reg  <= RST_TGT_COUNT;
            tgt_low_reg  <= RST_TGT_LOW;
            tgt_high_reg <= RST_TGT_HIGH;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_SRC_COUNT: src_cnt_reg  <= cfg_data[CNT_W-1:0];
                REG_SRC_LOW:   src_low_reg  <= cfg_data[EDGE_W-1:0];
                REG_SRC_HIGH:  src_high_reg <= cfg_data[EDGE_W-1:0];
                REG_TGT_COUNT: tgt_cnt_reg  <= cfg_data[CNT_W-1:0];
                REG_TGT_LOW:   tgt_low_reg  <= cfg_data[EDGE_W-1:0];
                REG_TGT_HIGH:  tgt_high_reg <= cfg_data[EDGE_W-1:0];
                default:       ;
            endcase
        end
    end

    logic        [CNT_W-1:0]  ns_eff;
    logic        [CNT_W-1:0]  nt_eff;
    logic signed [SPAN_W-1:0] span_s;
    logic signed [SPAN_W-1:0] span_t;

    assign ns_eff = (src_cnt_reg > CNT_W'(MAX_SRC_BINS)) ? CNT_W'(MAX_SRC_BINS) : src_cnt_reg;
    assign nt_eff = (tgt_cnt_reg > CNT_W'(MAX_TGT_BINS)) ? CNT_W'(MAX_TGT_BINS) : tgt_cnt_reg;
    assign span_s = SPAN_W'(src_high_reg) - SPAN_W'(src_low_reg);
    assign span_t = SPAN_W'(tgt_high_reg) - SPAN_W'(tgt_low_reg);

    // source store, filled in order; entries at or past the fill count read as zero
    logic             [CNT_W-1:0]  load_count_reg;
    logic                          load_beat;
    logic                          store_we;
    logic             [VAL_W-1:0]  ram_rdata;
    logic             [SRC_AW-1:0] i_reg;
    logic             [TGT_AW-1:0] j_reg;

    assign load_beat = s_tvalid && cmd.in_ready;
    assign store_we  = load_beat && (load_count_reg < ns_eff);

    hrbo_ram #(
        .WIDTH (VAL_W),
        .DEPTH (MAX_SRC_BINS)
    ) u_store (
        .clk   (clk),
        .we    (store_we),
        .waddr (load_count_reg[SRC_AW-1:0]),
        .wdata (s_tdata[VAL_W-1:0]),
        .raddr (i_reg),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            load_count_reg <= '0;
        end
        else if (cmd.set_done)
        begin
            load_count_reg <= '0;
        end
        else if (store_we)
        begin
            load_count_reg <= load_count_reg + CNT_W'(1);
        end
    end

    // setup products, all edges scaled by ns*nt
    logic signed [SPAN_W+CNT_W:0]  ds_prod;
    logic signed [SPAN_W+CNT_W:0]  dt_prod;
    logic signed [EDGE_W+SCALE_W:0] sbase_prod;
    logic signed [EDGE_W+SCALE_W:0] tbase_prod;
    logic        [SCALE_W-1:0]     scale_reg;
    logic signed [POS_W-1:0]       ds_reg;
    logic signed [POS_W-1:0]       dt_reg;
    logic signed [POS_W-1:0]       base_reg;
    logic signed [POS_W-1:0]       sl_reg;
    logic signed [POS_W-1:0]       sh_reg;
    logic signed [POS_W-1:0]       tl_reg;
    logic signed [POS_W-1:0]       th_reg;

    assign ds_prod    = span_s * $signed({1'b0, nt_eff});
    assign dt_prod    = span_t * $signed({1'b0, ns_eff});
    assign sbase_prod = src_low_reg * $signed({1'b0, scale_reg});
    assign tbase_prod = tgt_low_reg * $signed({1'b0, scale_reg});

    always_ff @(posedge clk)
    begin
        if (cmd.setup_scale)
        begin
            scale_reg <= SCALE_W'(ns_eff) * SCALE_W'(nt_eff);
            ds_reg    <= POS_W'(ds_prod);
            dt_reg    <= POS_W'(dt_prod);
        end
        if (cmd.setup_base)
        begin
            base_reg <= POS_W'(sbase_prod);
            tl_reg   <= POS_W'(tbase_prod);
        end
        if (cmd.setup_th)
        begin
            th_reg <= tl_reg + dt_reg;
            j_reg  <= '0;
        end
        if (cmd.tgt_next)
        begin
            tl_reg <= th_reg;
            th_reg <= th_reg + dt_reg;
            j_reg  <= j_reg + TGT_AW'(1);
        end
        if (cmd.row_init)
        begin
            sl_reg <= base_reg;
            sh_reg <= base_reg + ds_reg;
            i_reg  <= '0;
        end
        if (cmd.advance)
        begin
            sl_reg <= sh_reg;
            sh_reg <= sh_reg + ds_reg;
            i_reg  <= i_reg + SRC_AW'(1);
        end
    end

    // overlap of current source and target bin
    logic signed [POS_W-1:0] ov_lo;
    logic signed [POS_W-1:0] ov_hi;
    logic signed [POS_W-1:0] ov_len;

    assign ov_lo  = (sl_reg > tl_reg) ? sl_reg : tl_reg;
    assign ov_hi  = (sh_reg < th_reg) ? sh_reg : th_reg;
    assign ov_len = ov_hi - ov_lo;

    // restoring divider: weight = overlap * 2^16 / source width, one bit a cycle
    logic [DIV_W-1:0]  rem_reg;
    logic [Q_W-1:0]    q_reg;
    logic [DCNT_W-1:0] dcnt_reg;
    logic [DIV_W-1:0]  divisor;
    logic              q_bit;
    logic [DIV_W-1:0]  rem_diff;

    assign divisor  = ds_reg[DIV_W-1:0];
    assign q_bit    = rem_reg >= divisor;
    assign rem_diff = q_bit ? (rem_reg - divisor) : rem_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.div_start)
        begin
            rem_reg  <= ov_len[DIV_W-1:0];
            q_reg    <= '0;
            dcnt_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            rem_reg  <= {rem_diff[DIV_W-2:0], 1'b0};
            q_reg    <= {q_reg[Q_W-2:0], q_bit};
            dcnt_reg <= dcnt_reg + DCNT_W'(1);
        end
    end

    // multiply-accumulate
    logic signed [VAL_W-1:0]  src_val;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]  acc_reg;

    assign src_val = (CNT_W'(i_reg) < load_count_reg) ? ram_rdata : '0;

    always_ff @(posedge clk)
    begin
        if (cmd.mul)
        begin
            prod_reg <= PROD_W'(src_val * $signed({1'b0, q_reg}));
        end
        if (cmd.row_init)
        begin
            acc_reg <= '0;
        end
        else if (cmd.acc_add)
        begin
            acc_reg <= acc_reg + ACC_W'(prod_reg);
        end
    end

    // floor to Q26.16, then saturate to Q24.16
    logic signed [RES_W-1:0] res;
    logic                    res_fits;
    logic        [OUT_W-1:0] res_sat;

    assign res      = acc_reg[ACC_W-1:FRAC_W];
    assign res_fits = (res[RES_W-1:OUT_W-1] == '0) || (res[RES_W-1:OUT_W-1] == '1);
    assign res_sat  = res_fits ? res[OUT_W-1:0] :
                      (res[RES_W-1] ? {1'b1, {(OUT_W-1){1'b0}}} : {1'b0, {(OUT_W-1){1'b1}}});

    // output register
    logic             out_valid_reg;
    logic [IDX_W-1:0] out_idx_reg;
    logic [OUT_W-1:0] out_val_reg;
    logic             out_err_reg;
    logic             out_last_reg;
    logic             last_tgt;

    assign last_tgt = (CNT_W'(j_reg) + CNT_W'(1)) == nt_eff;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit_norm || cmd.emit_err)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit_norm)
        begin
            out_idx_reg  <= IDX_W'(j_reg);
            out_val_reg  <= res_sat;
            out_err_reg  <= 1'b0;
            out_last_reg <= last_tgt;
        end
        else if (cmd.emit_err)
        begin
            out_idx_reg  <= '0;
            out_val_reg  <= '0;
            out_err_reg  <= 1'b1;
            out_last_reg <= 1'b1;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(OUT_DATA_W-OUT_W-IDX_W){1'b0}}, out_val_reg, out_idx_reg};
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_err_reg;

    assign status.last_beat = load_beat && s_tlast;
    assign status.range_err = (ns_eff == '0) || (nt_eff == '0) ||
                              (span_s <= 0) || (span_t <= 0);
    assign status.overlap   = ov_hi > ov_lo;
    assign status.last_src  = (CNT_W'(i_reg) + CNT_W'(1)) == ns_eff;
    assign status.last_tgt  = last_tgt;
    assign status.div_done  = dcnt_reg == DCNT_W'(DIV_STEPS - 1);
    assign status.out_free  = !out_valid_reg || m_tready;

endmodule

`default_nettype wire

[rtl/core/hrbo_checker.sv]
// Port-level checks for the rebinning core, bound to its top level.
// Depends on hrbo_pkg and histogram_rebin_overlap_core.
`default_nettype none

module hrbo_checker (
    input wire logic                            clk,
    input wire logic                            rst_n,
    input wire logic                            s_tvalid,
    input wire logic                            s_tready,
    input wire logic                            s_tlast,
    input wire logic                            m_tvalid,
    input wire logic                            m_tready,
    input wire logic [hrbo_pkg::OUT_DATA_W-1:0] m_tdata,
    input wire logic                            m_tlast,
    input wire logic                            m_tuser
);
    import hrbo_pkg::*;

    // a stalled output beat stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("output beat dropped while stalled");

    // an error beat carries tlast, closing its run
    a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> m_tlast)
        else $error("error beat without tlast");

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> m_tdata == '0)
        else $error("error beat carries data");

    // closing a data set holds off input while computing
    a_hold_off: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && s_tlast |=> !s_tready)
        else $error("input taken right after the last bin");

endmodule

bind histogram_rebin_overlap_core hrbo_checker u_hrbo_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
);

`default_nettype wire
